// File: hdl/kcc_pkg.sv
package kcc_pkg;

  // charset codes as delivered on the result channel
  typedef enum logic [1:0] {
    CS_EUCKR = 2'd0,
    CS_CP949 = 2'd1,
    CS_JOHAB = 2'd2
  } charset_t;

  // lead byte classes, none means no trail expected
  typedef enum logic [2:0] {
    LC_NONE    = 3'd0,
    LC_84_A0   = 3'd1,
    LC_A1_C6   = 3'd2,
    LC_C7_D3   = 3'd3,
    LC_D4_D7   = 3'd4,
    LC_D8_FF   = 3'd5
  } lead_class_t;

  typedef struct packed {
    lead_class_t pend;
    logic        not_euc;
    logic        not_johab;
    logic        decided;
    charset_t    code;
  } kcc_state_t;

  typedef struct packed {
    charset_t code;
    logic     early;
  } kcc_result_t;

  localparam kcc_state_t KCC_STATE_RST = '{
    pend:      LC_NONE,
    not_euc:   1'b0,
    not_johab: 1'b0,
    decided:   1'b0,
    code:      CS_EUCKR
  };

  // class of a lead byte, 0x81..0x83 are handled apart
  function automatic lead_class_t lead_class(input logic [7:0] b);
    lead_class_t cls;
    cls = LC_NONE;
    if (b >= 8'hD8) begin
      cls = LC_D8_FF;
    end else if (b >= 8'hD4) begin
      cls = LC_D4_D7;
    end else if (b >= 8'hC7) begin
      cls = LC_C7_D3;
    end else if (b >= 8'hA1) begin
      cls = LC_A1_C6;
    end else if (b >= 8'h84) begin
      cls = LC_84_A0;
    end
    return cls;
  endfunction

  function automatic logic is_johab_trail(input logic [7:0] b);
    return ((b >= 8'h5B) && (b <= 8'h60)) || ((b >= 8'h7B) && (b <= 8'h80));
  endfunction

  function automatic logic is_cp949_trail_low(input logic [7:0] b);
    return (b == 8'h52) || (b == 8'h72) || (b == 8'h92) ||
           ((b >= 8'h9E) && (b <= 8'hA0));
  endfunction

  function automatic logic is_cp949_trail_high(input logic [7:0] b);
    return (b == 8'hB2) || ((b >= 8'hBE) && (b <= 8'hC0)) || (b == 8'hD2) ||
           ((b >= 8'hDE) && (b <= 8'hE0)) || (b == 8'hF2) || (b == 8'hFE);
  endfunction

endpackage

// File: hdl/kcc_if.sv
interface kcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface kcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] charset_code;
  logic       decided_early;

  modport source (output valid, charset_code, decided_early, input ready);
  modport sink   (input valid, charset_code, decided_early, output ready);
endinterface

// File: hdl/kcc_step.sv
module kcc_step
  import kcc_pkg::*;
(
  input  kcc_state_t  state,
  input  logic [7:0]  text_byte,
  output kcc_state_t  state_nxt,
  output kcc_result_t result
);

  kcc_state_t  nxt;
  lead_class_t cls;

  always_comb begin
    nxt = state;
    cls = lead_class(text_byte);
    if (!state.decided) begin
      if (state.pend != LC_NONE) begin
        nxt.pend = LC_NONE;
        unique case (state.pend)
          LC_84_A0: begin
            if (is_johab_trail(text_byte)) begin
              nxt.decided = 1'b1;
              nxt.code    = CS_JOHAB;
            end else if (is_cp949_trail_low(text_byte) ||
                         is_cp949_trail_high(text_byte)) begin
              nxt.decided = 1'b1;
              nxt.code    = CS_CP949;
            end
          end
          LC_A1_C6: begin
            if (text_byte < 8'hA1) begin
              nxt.not_euc = 1'b1;
              if (is_johab_trail(text_byte)) begin
                nxt.decided = 1'b1;
                nxt.code    = CS_JOHAB;
              end else if (is_cp949_trail_low(text_byte)) begin
                nxt.decided = 1'b1;
                nxt.code    = CS_CP949;
              end
            end
          end
          LC_C7_D3, LC_D8_FF: begin
            if (text_byte < 8'hA1) begin
              nxt.decided = 1'b1;
              nxt.code    = CS_JOHAB;
            end
          end
          default: begin
            // trail after 0xd4..0xd7 is only consumed
          end
        endcase
      end else if ((text_byte >= 8'h81) && (text_byte <= 8'h83)) begin
        nxt.decided = 1'b1;
        nxt.code    = CS_CP949;
      end else begin
        nxt.pend = cls;
        if (cls == LC_84_A0) begin
          nxt.not_euc = 1'b1;
        end
        if (cls == LC_D4_D7) begin
          nxt.not_johab = 1'b1;
        end
      end
      if (!nxt.decided && nxt.not_euc && nxt.not_johab) begin
        nxt.decided = 1'b1;
        nxt.code    = CS_CP949;
      end
    end
  end

  assign state_nxt = nxt;

  always_comb begin
    if (nxt.decided) begin
      result.code  = nxt.code;
      result.early = 1'b1;
    end else begin
      result.code  = nxt.not_euc ? CS_CP949 : CS_EUCKR;
      result.early = 1'b0;
    end
  end

endmodule

// File: hdl/korean_charset_classifier.sv
// a byte is registered in the input stage at acceptance; the result of a
// marked byte is registered in the result register as it leaves that stage.
// throughput: one byte per cycle, set by the state update loop, except that
// a marked byte waits while a held result is not taken. only the byte marked
// end_of_text yields a result; the classifier state clears after it. reset
// (rst_n low, synchronous) empties both stages and clears the classifier state
module korean_charset_classifier
  import kcc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  kcc_in_if.sink          in_ch,
  kcc_out_if.source       out_ch
);

  // input stage
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;

  // classifier state
  kcc_state_t  state_r, state_nxt;
  kcc_state_t  step_nxt;
  kcc_result_t step_res;

  // result register
  logic        out_valid_r, out_valid_nxt;
  kcc_result_t out_r;

  logic in_fire;
  logic s1_adv;
  logic s1_fire;

  // a byte without the end mark never needs the result register,
  // a marked byte moves on once the result register is free or draining
  assign s1_adv  = !s1_last_r || !out_valid_r || out_ch.ready;
  assign s1_fire = s1_valid_r && s1_adv;

  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  kcc_step u_step (
    .state     (state_r),
    .text_byte (s1_byte_r),
    .state_nxt (step_nxt),
    .result    (step_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // end of text returns the state to reset for the next text
  always_comb begin
    state_nxt = state_r;
    if (s1_fire) begin
      state_nxt = s1_last_r ? KCC_STATE_RST : step_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= KCC_STATE_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.text_byte;
      s1_last_r <= in_ch.end_of_text;
    end
    if (s1_fire && s1_last_r) begin
      out_r <= step_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.charset_code  = out_r.code;
  assign out_ch.decided_early = out_r.early;

  // after the marked byte the state is back at reset
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (state_r == KCC_STATE_RST))
    else $error("state not cleared after end of text");

  // a byte pattern never decides euc-kr
  a_decided_code: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.decided |-> (state_r.code != CS_EUCKR))
    else $error("euc-kr held as a decision");

  // both flags set always forces a decision
  a_flags_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.not_euc && state_r.not_johab) |-> state_r.decided)
    else $error("both flags set without decision");

  // a held result is not overwritten by the next marked byte
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !(s1_fire && s1_last_r))
    else $error("result overwritten while stalled");

endmodule

// File: test/kcc_verdict_checker.sv
module kcc_verdict_checker
  import kcc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  kcc_in_if    in_ch,
  kcc_out_if   out_ch,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted classifier state
  lead_class_t pend_lead   = LC_NONE;
  logic        saw_not_euc   = 1'b0;
  logic        saw_not_johab = 1'b0;
  logic        locked        = 1'b0;
  charset_t    locked_code   = CS_EUCKR;

  kcc_result_t verdicts_due[$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic johab_trail_byte(input logic [7:0] b);
    return ((b >= 8'h5B) && (b <= 8'h60)) || ((b >= 8'h7B) && (b <= 8'h80));
  endfunction

  function automatic logic cp949_trail_low_byte(input logic [7:0] b);
    return (b == 8'h52) || (b == 8'h72) || (b == 8'h92) || ((b >= 8'h9E) && (b <= 8'hA0));
  endfunction

  task automatic clear_guess();
    pend_lead     = LC_NONE;
    saw_not_euc   = 1'b0;
    saw_not_johab = 1'b0;
    locked        = 1'b0;
    locked_code   = CS_EUCKR;
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic predict_charset(input logic [7:0] b, input logic last);
    lead_class_t cls;
    kcc_result_t verdict;
    if (!locked) begin
      if (pend_lead != LC_NONE) begin
        cls = pend_lead;
        pend_lead = LC_NONE;
        case (cls)
          LC_84_A0: begin
            if (johab_trail_byte(b)) begin
              locked = 1'b1;
              locked_code = CS_JOHAB;
            end else if (cp949_trail_low_byte(b) || (b == 8'hB2) ||
                         ((b >= 8'hBE) && (b <= 8'hC0)) || (b == 8'hD2) ||
                         ((b >= 8'hDE) && (b <= 8'hE0)) || (b == 8'hF2) ||
                         (b == 8'hFE)) begin
              locked = 1'b1;
              locked_code = CS_CP949;
            end
          end
          LC_A1_C6: begin
            if (b < 8'hA1) begin
              saw_not_euc = 1'b1;
              if (johab_trail_byte(b)) begin
                locked = 1'b1;
                locked_code = CS_JOHAB;
              end else if (cp949_trail_low_byte(b)) begin
                locked = 1'b1;
                locked_code = CS_CP949;
              end
            end
          end
          LC_C7_D3, LC_D8_FF: begin
            if (b < 8'hA1) begin
              locked = 1'b1;
              locked_code = CS_JOHAB;
            end
          end
          default: ;
        endcase
      end else if ((b >= 8'h81) && (b <= 8'h83)) begin
        locked = 1'b1;
        locked_code = CS_CP949;
      end else if ((b >= 8'h84) && (b <= 8'hA0)) begin
        saw_not_euc = 1'b1;
        pend_lead = LC_84_A0;
      end else if ((b >= 8'hA1) && (b <= 8'hC6)) begin
        pend_lead = LC_A1_C6;
      end else if ((b >= 8'hC7) && (b <= 8'hD3)) begin
        pend_lead = LC_C7_D3;
      end else if ((b >= 8'hD4) && (b <= 8'hD7)) begin
        saw_not_johab = 1'b1;
        pend_lead = LC_D4_D7;
      end else if (b >= 8'hD8) begin
        pend_lead = LC_D8_FF;
      end
      if (!locked && saw_not_euc && saw_not_johab) begin
        locked = 1'b1;
        locked_code = CS_CP949;
      end
    end
    if (last) begin
      verdict.code  = locked ? locked_code : (saw_not_euc ? CS_CP949 : CS_EUCKR);
      verdict.early = locked;
      verdicts_due.push_back(verdict);
      clear_guess();
    end
  endtask

  always @(posedge clk) begin
    kcc_result_t due;
    if (!rst_n) begin
      clear_guess();
      verdicts_due.delete();
    end else begin
      // results first, a request taken at this edge cannot have its result yet
      if (out_ch.valid && out_ch.ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result code=%0d early=%0b",
                                    out_ch.charset_code, out_ch.decided_early));
        end else begin
          due = verdicts_due.pop_front();
          if (out_ch.charset_code !== due.code) begin
            report_mismatch($sformatf("charset_code got %0d want %0d",
                                      out_ch.charset_code, due.code));
          end
          if (out_ch.decided_early !== due.early) begin
            report_mismatch($sformatf("decided_early got %0b want %0b",
                                      out_ch.decided_early, due.early));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_charset(in_ch.text_byte, in_ch.end_of_text);
      end
    end
    pending_count <= verdicts_due.size();
  end

endmodule

// File: test/tb_korean_charset_classifier.sv
module tb_korean_charset_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import kcc_pkg::*;

  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT  = 200;
  // rough number of random bytes to push
  localparam int RANDOM_BYTES = 1050;

  typedef logic [7:0] text_t[$];

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   quiet_cycles = 0;
  logic src_calm = 1'b0;

  kcc_in_if  in_ch();
  kcc_out_if out_ch();

  korean_charset_classifier uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  kcc_verdict_checker verdict_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // push one text, end_of_text goes on its final byte
  task automatic send_text(input text_t txt);
    int gap;
    for (int i = 0; i < txt.size(); i++) begin
      // calm texts go back to back, others get a random gap per request
      gap = src_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid       <= 1'b1;
      in_ch.text_byte   <= txt[i];
      in_ch.end_of_text <= (i == txt.size() - 1);
      @(posedge clk);
      // ready read here is the value from before the edge
      while (!in_ch.ready) @(posedge clk);
    end
  endtask

  // random text built from pieces that look like real encodings
  function automatic text_t make_text();
    text_t t;
    int    pieces;
    int    kind;
    logic  plain;
    logic [7:0] b;
    // plain texts hold only ascii and euc pairs so the fallback rule is reached
    plain  = ($urandom_range(0, 3) == 0);
    pieces = $urandom_range(1, 6);
    for (int p = 0; p < pieces; p++) begin
      kind = plain ? $urandom_range(0, 3) : $urandom_range(0, 9);
      case (kind)
        0, 1: t.push_back(8'($urandom_range(8'h20, 8'h7E)));
        2, 3: begin
          // euc-kr pair
          t.push_back(8'($urandom_range(8'hA1, 8'hFE)));
          t.push_back(8'($urandom_range(8'hA1, 8'hFE)));
        end
        4: begin
          // johab style pair
          t.push_back(8'($urandom_range(8'h84, 8'hD3)));
          if ($urandom_range(0, 1) == 1) begin
            t.push_back(8'($urandom_range(8'h41, 8'h7E)));
          end else begin
            t.push_back(8'($urandom_range(8'h81, 8'hFE)));
          end
        end
        5: begin
          // cp949 extension pair
          t.push_back(8'($urandom_range(8'h81, 8'hC6)));
          case ($urandom_range(0, 2))
            0:       b = 8'($urandom_range(8'h41, 8'h5A));
            1:       b = 8'($urandom_range(8'h61, 8'h7A));
            default: b = 8'($urandom_range(8'h81, 8'hFE));
          endcase
          t.push_back(b);
        end
        6: begin
          // lead that sets not-johab, trail not looked at
          t.push_back(8'($urandom_range(8'hD4, 8'hD7)));
          t.push_back(8'($urandom_range(0, 255)));
        end
        7: begin
          // euc lead range with a low trail, sets not-euc
          t.push_back(8'($urandom_range(8'hA1, 8'hC6)));
          t.push_back(8'($urandom_range(8'h00, 8'hA0)));
        end
        8: t.push_back(8'($urandom_range(0, 255)));
        default: begin
          t.push_back(8'($urandom_range(0, 255)));
          t.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    return t;
  endfunction

  // result side: random stall before each result, with quiet stretches
  initial begin
    int   gap;
    logic sink_calm;
    sink_calm = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
      gap = sink_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // hang detector, any handshake on either side counts as progress
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    text_t t;
    int    sent;
    sent = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.text_byte   <= 8'h00;
    in_ch.end_of_text <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed texts
    // single ascii byte, falls back to euc-kr
    send_text('{8'h41});
    // zero byte, ignored as a lead
    send_text('{8'h00});
    // 0x81..0x83 lead decides cp949 at once
    send_text('{8'h81});
    // class 84-a0 with a johab trail
    send_text('{8'h84, 8'h5B});
    // class 84-a0 with the highest cp949 trail
    send_text('{8'hA0, 8'hFE});
    // lead marked last, only its not-euc flag counts
    send_text('{8'h84});
    // plain euc-kr pair
    send_text('{8'hA1, 8'hA1});
    // class a1-c6 with a cp949 trail
    send_text('{8'hC6, 8'h52});
    // class a1-c6 with a johab trail
    send_text('{8'hA1, 8'h7B});
    // class c7-d3 with a low trail decides johab
    send_text('{8'hC7, 8'h00});
    // both flags set at a lead byte marked last
    send_text('{8'hD4, 8'h00, 8'h84});
    // top class with a high trail stays euc-kr
    send_text('{8'hFF, 8'hFF});
    // bytes after a decision are ignored
    send_text('{8'h83, 8'h5B, 8'hFF});

    // random texts
    while (sent < RANDOM_BYTES) begin
      t = make_text();
      src_calm = ($urandom_range(0, 4) == 0);
      send_text(t);
      sent += t.size();
    end
    in_ch.valid <= 1'b0;

    // drain, then let the pipeline settle
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
